// ----- hdl/ipms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the incremental PID motor and steering block.
// Used by the top level and by the datapath; depends on nothing else.
package ipms_pkg;

	localparam int DATA_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ERR_W     = 17;
	localparam int D1_W      = 18;
	localparam int D2_W      = 19;
	localparam int PROD_P_W  = 35;
	localparam int PROD_I_W  = 34;
	localparam int PROD_D_W  = 36;
	localparam int PROD_S_W  = 33;
	localparam int RAW_W     = 37;
	localparam int STEP_W    = 29;
	localparam int TERM_W    = 25;
	localparam int SERVO_W   = 26;
	localparam int ACC_W     = 30;
	localparam int FRAC_W    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_STEER_GAIN   = 3'd3,
		REG_SERVO_CENTRE = 3'd4
	} cfg_reg_t;

	localparam logic [DATA_W-1:0] GAIN_P_RST       = 16'd2048;
	localparam logic [DATA_W-1:0] GAIN_I_RST       = 16'd1536;
	localparam logic [DATA_W-1:0] GAIN_D_RST       = 16'd0;
	localparam logic [DATA_W-1:0] STEER_GAIN_RST   = 16'd1408;
	localparam logic [DATA_W-1:0] SERVO_CENTRE_RST = 16'd0;

	typedef struct packed {
		logic [DATA_W-1:0] gain_p;
		logic [DATA_W-1:0] gain_i;
		logic [DATA_W-1:0] gain_d;
		logic [DATA_W-1:0] steer_gain;
		logic [DATA_W-1:0] servo_centre;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic adv_out;
	} pipe_en_t;

endpackage

// ----- hdl/ipms_datapath.sv -----
`timescale 1ns / 1ps
// Single-pass datapath: input register, error history, gain products, saturating accumulator.
// Depends on ipms_pkg; register enables come from the top level.
module ipms_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ipms_pkg::pipe_en_t                   en,
	input  ipms_pkg::cfg_t                       cfg,
	input  logic signed [ipms_pkg::DATA_W-1:0]   target_speed,
	input  logic signed [ipms_pkg::DATA_W-1:0]   measured_speed,
	input  logic signed [ipms_pkg::DATA_W-1:0]   direction_error,
	input  logic                                 stop,
	output logic        [ipms_pkg::DATA_W-1:0]   servo_drive,
	output logic signed [ipms_pkg::DATA_W-1:0]   motor_drive
);

	logic signed [ipms_pkg::DATA_W-1:0]  target_s1, measured_s1, dir_s1;
	logic                                stop_s1;

	logic signed [ipms_pkg::ERR_W-1:0]   e_now_q, e_prev_q;
	logic signed [ipms_pkg::DATA_W-1:0]  acc_q;

	logic signed [ipms_pkg::ERR_W-1:0]   err;
	logic signed [ipms_pkg::D1_W-1:0]    d1;
	logic signed [ipms_pkg::D2_W-1:0]    d2;

	logic signed [ipms_pkg::PROD_P_W-1:0] prod_p;
	logic signed [ipms_pkg::PROD_I_W-1:0] prod_i;
	logic signed [ipms_pkg::PROD_D_W-1:0] prod_d;
	logic signed [ipms_pkg::PROD_S_W-1:0] prod_s;

	logic signed [ipms_pkg::RAW_W-1:0]    raw, raw_adj;
	logic signed [ipms_pkg::STEP_W-1:0]   step;
	logic signed [ipms_pkg::PROD_S_W-1:0] steer_adj;
	logic signed [ipms_pkg::TERM_W-1:0]   term;
	logic signed [ipms_pkg::SERVO_W-1:0]  servo_sum;
	logic        [ipms_pkg::DATA_W-1:0]   servo_sat;

	logic signed [ipms_pkg::ACC_W-1:0]    acc_diff;
	logic signed [ipms_pkg::DATA_W-1:0]   acc_next;

	logic        [ipms_pkg::DATA_W-1:0]   servo_q;
	logic signed [ipms_pkg::DATA_W-1:0]   motor_q;

	always_comb begin
		err = $signed({target_s1[ipms_pkg::DATA_W-1], target_s1})
			- $signed({measured_s1[ipms_pkg::DATA_W-1], measured_s1});
		d1 = $signed({err[ipms_pkg::ERR_W-1], err})
			- $signed({e_now_q[ipms_pkg::ERR_W-1], e_now_q});
		d2 = $signed({{2{err[ipms_pkg::ERR_W-1]}}, err})
			- $signed({e_now_q[ipms_pkg::ERR_W-1], e_now_q, 1'b0})
			+ $signed({{2{e_prev_q[ipms_pkg::ERR_W-1]}}, e_prev_q});
	end

	always_comb begin
		prod_p = ipms_pkg::PROD_P_W'($signed({1'b0, cfg.gain_p}))
			* ipms_pkg::PROD_P_W'(d1);
		prod_i = ipms_pkg::PROD_I_W'($signed({1'b0, cfg.gain_i}))
			* ipms_pkg::PROD_I_W'(err);
		prod_d = ipms_pkg::PROD_D_W'($signed({1'b0, cfg.gain_d}))
			* ipms_pkg::PROD_D_W'(d2);
		prod_s = ipms_pkg::PROD_S_W'($signed({1'b0, cfg.steer_gain}))
			* ipms_pkg::PROD_S_W'(dir_s1);

		raw = ipms_pkg::RAW_W'(prod_p) + ipms_pkg::RAW_W'(prod_i)
			+ ipms_pkg::RAW_W'(prod_d);
		raw_adj = raw[ipms_pkg::RAW_W-1] ? raw + ipms_pkg::RAW_W'(255) : raw;
		step = raw_adj[ipms_pkg::RAW_W-1:ipms_pkg::FRAC_W];

		steer_adj = prod_s[ipms_pkg::PROD_S_W-1]
			? prod_s + ipms_pkg::PROD_S_W'(255) : prod_s;
		term = steer_adj[ipms_pkg::PROD_S_W-1:ipms_pkg::FRAC_W];
		servo_sum = $signed({10'd0, cfg.servo_centre}) + ipms_pkg::SERVO_W'(term);
		if (servo_sum[ipms_pkg::SERVO_W-1]) begin
			servo_sat = '0;
		end else if (servo_sum[ipms_pkg::SERVO_W-2:ipms_pkg::DATA_W] != '0) begin
			servo_sat = '1;
		end else begin
			servo_sat = servo_sum[ipms_pkg::DATA_W-1:0];
		end
	end

	always_comb begin
		acc_diff = ipms_pkg::ACC_W'(acc_q) - ipms_pkg::ACC_W'(step);
		if (acc_diff[ipms_pkg::ACC_W-1:ipms_pkg::DATA_W-1] == '0
				|| acc_diff[ipms_pkg::ACC_W-1:ipms_pkg::DATA_W-1] == '1) begin
			acc_next = acc_diff[ipms_pkg::DATA_W-1:0];
		end else if (acc_diff[ipms_pkg::ACC_W-1]) begin
			acc_next = {1'b1, {(ipms_pkg::DATA_W-1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(ipms_pkg::DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s1) begin
			target_s1   <= target_speed;
			measured_s1 <= measured_speed;
			dir_s1      <= direction_error;
			stop_s1     <= stop;
		end
		if (en.adv_out) begin
			servo_q <= stop_s1 ? cfg.servo_centre : servo_sat;
			motor_q <= stop_s1 ? '0 : acc_next;
		end
	end

	// The speed error history and the drive accumulator only move on running ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_now_q  <= '0;
			e_prev_q <= '0;
			acc_q    <= '0;
		end else if (en.adv_out && !stop_s1) begin
			e_prev_q <= e_now_q;
			e_now_q  <= err;
			acc_q    <= acc_next;
		end
	end

	assign servo_drive = servo_q;
	assign motor_drive = motor_q;

endmodule

// ----- hdl/incremental_pid_motor_and_steering.sv -----
`timescale 1ns / 1ps
// Incremental PID motor drive with proportional steering, top level.
// A transfer fills the input register; the result register takes it when the output can move.
// Throughput: one item per cycle; the input register waits only while a result is stalled.
// Reset clears both valid bits, the error history and the accumulator,
// and loads the gain and centre registers with their defaults.
// Depends on ipms_pkg and ipms_datapath.
module incremental_pid_motor_and_steering (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ipms_pkg::DATA_W-1:0]   target_speed,
	input  logic signed [ipms_pkg::DATA_W-1:0]   measured_speed,
	input  logic signed [ipms_pkg::DATA_W-1:0]   direction_error,
	input  logic                                 stop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [ipms_pkg::DATA_W-1:0]   servo_drive,
	output logic signed [ipms_pkg::DATA_W-1:0]   motor_drive,
	input  logic                                 cfg_wr_en,
	input  logic        [ipms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [ipms_pkg::DATA_W-1:0]   cfg_data
);

	ipms_pkg::cfg_t     cfg_q;
	ipms_pkg::pipe_en_t en;
	logic valid_s1, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= ipms_pkg::GAIN_P_RST;
			cfg_q.gain_i       <= ipms_pkg::GAIN_I_RST;
			cfg_q.gain_d       <= ipms_pkg::GAIN_D_RST;
			cfg_q.steer_gain   <= ipms_pkg::STEER_GAIN_RST;
			cfg_q.servo_centre <= ipms_pkg::SERVO_CENTRE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ipms_pkg::REG_GAIN_P:       cfg_q.gain_p       <= cfg_data;
				ipms_pkg::REG_GAIN_I:       cfg_q.gain_i       <= cfg_data;
				ipms_pkg::REG_GAIN_D:       cfg_q.gain_d       <= cfg_data;
				ipms_pkg::REG_STEER_GAIN:   cfg_q.steer_gain   <= cfg_data;
				ipms_pkg::REG_SERVO_CENTRE: cfg_q.servo_centre <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The input register moves to the result register when that is empty or being taken.
	always_comb begin
		en.adv_out = valid_s1 && (!out_valid_q || out_ready);
		in_ready   = !valid_s1 || en.adv_out;
		en.load_s1 = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.load_s1) begin
				valid_s1 <= 1'b1;
			end else if (en.adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (en.adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	ipms_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.cfg             (cfg_q),
		.target_speed    (target_speed),
		.measured_speed  (measured_speed),
		.direction_error (direction_error),
		.stop            (stop),
		.servo_drive     (servo_drive),
		.motor_drive     (motor_drive)
	);

endmodule

// ----- hdl/ipms_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the incremental PID motor and steering block.
// Attached to the top level by the bind statement at the end of this file.
module ipms_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 stop,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [ipms_pkg::DATA_W-1:0]   servo_drive,
	input logic signed [ipms_pkg::DATA_W-1:0]   motor_drive
);

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(servo_drive) && $stable(motor_drive))
		else $error("result changed while stalled");

	// With the output free or draining, the block always takes a new transfer.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with output free");

	// A stop tick shows zero motor drive once the output is ready in the cycle after its transfer.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && stop ##1 out_ready |=> out_valid && motor_drive == '0)
		else $error("stop tick gave nonzero motor drive");

	// No result is offered right after reset is released.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered out of reset");

endmodule

bind incremental_pid_motor_and_steering ipms_checker u_ipms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.stop        (stop),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.servo_drive (servo_drive),
	.motor_drive (motor_drive)
);

// ----- tb/incremental_pid_motor_and_steering_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_motor_and_steering: directed and random control
// ticks under changing gain settings, checked against a cycle-free model of the controller.
// Depends on ipms_pkg and the RTL of the block.
module incremental_pid_motor_and_steering_tb;

	typedef struct {
		logic signed [ipms_pkg::DATA_W-1:0] target;
		logic signed [ipms_pkg::DATA_W-1:0] measured;
		logic signed [ipms_pkg::DATA_W-1:0] dir;
		logic                               stop;
	} tick_t;

	typedef struct {
		logic        [ipms_pkg::DATA_W-1:0] servo;
		logic signed [ipms_pkg::DATA_W-1:0] motor;
	} drive_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [ipms_pkg::DATA_W-1:0] target_speed = '0;
	logic signed [ipms_pkg::DATA_W-1:0] measured_speed = '0;
	logic signed [ipms_pkg::DATA_W-1:0] direction_error = '0;
	logic                               stop = 1'b0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic        [ipms_pkg::DATA_W-1:0] servo_drive;
	logic signed [ipms_pkg::DATA_W-1:0] motor_drive;
	logic                               cfg_wr_en = 1'b0;
	logic     [ipms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic        [ipms_pkg::DATA_W-1:0] cfg_data = '0;

	incremental_pid_motor_and_steering dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.target_speed(target_speed),
		.measured_speed(measured_speed),
		.direction_error(direction_error),
		.stop(stop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.servo_drive(servo_drive),
		.motor_drive(motor_drive),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tick_t  tick_q[$];
	drive_t drive_q[$];
	tick_t  drv_tick;
	tick_t  seen_tick;
	drive_t want;

	ipms_pkg::cfg_t                     gains;
	logic signed [ipms_pkg::ERR_W-1:0]  err_now;
	logic signed [ipms_pkg::ERR_W-1:0]  err_prev;
	logic signed [ipms_pkg::ERR_W-1:0]  err_prev2;
	logic signed [ipms_pkg::DATA_W-1:0] drive_acc;

	logic in_fire = 1'b0;
	int   gap_left = 0;
	int   burst_left = 1;
	int   gap_max = 0;
	int   stall_pct = 0;
	int   err_count = 0;
	int   ticks_taken = 0;
	int   stop_ticks = 0;
	int   results_checked = 0;
	int   settings_used = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Steering and motor drive for one tick; a tick without stop advances the speed error history and accumulator.
	function automatic drive_t next_drive(tick_t t);
		drive_t d;
		longint term;
		longint servo_sum;
		longint e;
		longint e1;
		longint e2;
		longint raw;
		longint acc;
		if (t.stop) begin
			d.servo = gains.servo_centre;
			d.motor = '0;
			return d;
		end
		term = (longint'(gains.steer_gain) * longint'(t.dir)) / 256;
		servo_sum = clamp(longint'(gains.servo_centre) + term, 0, 65535);
		d.servo = servo_sum[ipms_pkg::DATA_W-1:0];
		err_prev2 = err_prev;
		err_prev = err_now;
		e = longint'(t.target) - longint'(t.measured);
		err_now = e[ipms_pkg::ERR_W-1:0];
		e1 = longint'(err_prev);
		e2 = longint'(err_prev2);
		raw = longint'(gains.gain_p) * (e - e1) + longint'(gains.gain_i) * e
			+ longint'(gains.gain_d) * (e - 2 * e1 + e2);
		acc = clamp(longint'(drive_acc) - raw / 256, -32768, 32767);
		drive_acc = acc[ipms_pkg::DATA_W-1:0];
		d.motor = drive_acc;
		return d;
	endfunction

	task automatic report_mismatch(string what, logic [ipms_pkg::DATA_W-1:0] got,
		logic [ipms_pkg::DATA_W-1:0] exp_val);
		$display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got, exp_val);
		err_count++;
	endtask

	// Sender: bursts of transfers separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				drv_tick = tick_q.pop_front();
				target_speed <= drv_tick.target;
				measured_speed <= drv_tick.measured;
				direction_error <= drv_tick.dir;
				stop <= drv_tick.stop;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= $urandom_range(0, gap_max);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Observes both channels and the register port, predicts and checks results.
	always @(posedge clk) begin
		if (!arst_n) begin
			gains.gain_p = ipms_pkg::GAIN_P_RST;
			gains.gain_i = ipms_pkg::GAIN_I_RST;
			gains.gain_d = ipms_pkg::GAIN_D_RST;
			gains.steer_gain = ipms_pkg::STEER_GAIN_RST;
			gains.servo_centre = ipms_pkg::SERVO_CENTRE_RST;
			err_now = '0;
			err_prev = '0;
			err_prev2 = '0;
			drive_acc = '0;
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (cfg_wr_en) begin
				case (cfg_index)
					ipms_pkg::REG_GAIN_P:       gains.gain_p = cfg_data;
					ipms_pkg::REG_GAIN_I:       gains.gain_i = cfg_data;
					ipms_pkg::REG_GAIN_D:       gains.gain_d = cfg_data;
					ipms_pkg::REG_STEER_GAIN:   gains.steer_gain = cfg_data;
					ipms_pkg::REG_SERVO_CENTRE: gains.servo_centre = cfg_data;
					default:                    ;
				endcase
			end
			if (in_valid && in_ready) begin
				seen_tick.target = target_speed;
				seen_tick.measured = measured_speed;
				seen_tick.dir = direction_error;
				seen_tick.stop = stop;
				drive_q.push_back(next_drive(seen_tick));
				ticks_taken++;
				if (stop)
					stop_ticks++;
			end
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					report_mismatch("servo_drive with no transfer pending", servo_drive, '0);
				end else begin
					want = drive_q.pop_front();
					if (servo_drive !== want.servo)
						report_mismatch("servo_drive", servo_drive, want.servo);
					if (motor_drive !== want.motor)
						report_mismatch("motor_drive", motor_drive, want.motor);
					results_checked++;
				end
			end
		end
	end

	task automatic push_tick(int t, int m, int d, bit s);
		tick_t k;
		k.target = t[ipms_pkg::DATA_W-1:0];
		k.measured = m[ipms_pkg::DATA_W-1:0];
		k.dir = d[ipms_pkg::DATA_W-1:0];
		k.stop = s;
		tick_q.push_back(k);
	endtask

	function automatic int pick_edge();
		case ($urandom_range(0, 4))
			0:       return -32768;
			1:       return -1;
			2:       return 0;
			3:       return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic push_random_tick();
		int tgt;
		case ($urandom_range(0, 9))
			0: push_tick($urandom, $urandom, $urandom, 1'b1);
			1: push_tick($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
			2: push_tick(pick_edge(), pick_edge(), pick_edge(), 1'b0);
			default: begin
				tgt = int'($urandom_range(0, 4000)) - 2000;
				push_tick(tgt, tgt + int'($urandom_range(0, 200)) - 100,
					int'($urandom_range(0, 1000)) - 500, 1'b0);
			end
		endcase
	endtask

	task automatic write_reg(logic [ipms_pkg::CFG_IDX_W-1:0] idx,
		logic [ipms_pkg::DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || in_valid || drive_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic load_gains(logic [ipms_pkg::DATA_W-1:0] gp, logic [ipms_pkg::DATA_W-1:0] gi,
		logic [ipms_pkg::DATA_W-1:0] gd, logic [ipms_pkg::DATA_W-1:0] sg,
		logic [ipms_pkg::DATA_W-1:0] sc);
		write_reg(ipms_pkg::REG_GAIN_P, gp);
		write_reg(ipms_pkg::REG_GAIN_I, gi);
		write_reg(ipms_pkg::REG_GAIN_D, gd);
		write_reg(ipms_pkg::REG_STEER_GAIN, sg);
		write_reg(ipms_pkg::REG_SERVO_CENTRE, sc);
		// Indexes past the register list must leave every register alone.
		write_reg(ipms_pkg::CFG_IDX_W'(ipms_pkg::REG_SERVO_CENTRE)
			+ ipms_pkg::CFG_IDX_W'($urandom_range(1, 3)), ipms_pkg::DATA_W'($urandom));
		settings_used++;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		stall_pct = 30;
		gap_max = 3;
		push_tick(0, 0, 0, 1'b0);
		push_tick(32767, -32768, 32767, 1'b0);
		push_tick(-32768, 32767, -32768, 1'b0);
		push_tick(32767, -32768, 0, 1'b0);
		push_tick(100, 0, 500, 1'b1);
		push_tick(-32768, 32767, 32767, 1'b1);
		push_tick(100, 0, -1, 1'b0);
		push_tick(0, 0, 1, 1'b0);
		push_tick(-1, 0, -1, 1'b0);
		push_tick(0, 32767, 0, 1'b0);
		push_tick(16, 0, 300, 1'b0);
		push_tick(16, 0, -300, 1'b0);
		wait_drained();

		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
		push_tick(1, 0, 1, 1'b0);
		push_tick(-1, 0, -1, 1'b0);
		push_tick(300, -200, 32767, 1'b0);
		push_tick(0, 0, -32768, 1'b1);
		push_tick(-300, 200, -32768, 1'b0);
		push_tick(2, 1, 3, 1'b0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       load_gains('0, '0, '0, '0, '0);
				1:       load_gains('1, '1, '1, '1, '1);
				2:       load_gains(ipms_pkg::GAIN_P_RST, ipms_pkg::GAIN_I_RST,
						ipms_pkg::GAIN_D_RST, ipms_pkg::STEER_GAIN_RST,
						ipms_pkg::SERVO_CENTRE_RST);
				3, 4:    load_gains(ipms_pkg::DATA_W'($urandom_range(0, 2048)),
						ipms_pkg::DATA_W'($urandom_range(0, 2048)),
						ipms_pkg::DATA_W'($urandom_range(0, 1024)),
						ipms_pkg::DATA_W'($urandom_range(0, 4096)),
						ipms_pkg::DATA_W'($urandom));
				default: load_gains(ipms_pkg::DATA_W'($urandom), ipms_pkg::DATA_W'($urandom),
						ipms_pkg::DATA_W'($urandom), ipms_pkg::DATA_W'($urandom),
						ipms_pkg::DATA_W'($urandom));
			endcase
			stall_pct = (p == 0) ? 0 : $urandom_range(0, 70);
			gap_max = (p == 0) ? 0 : $urandom_range(0, 6);
			for (int i = 0; i < 210; i++) begin
				push_random_tick();
				// Mid-phase, hold the sender until the pipeline has emptied.
				if (p == 3 && i == 100)
					wait_drained();
			end
			wait_drained();
		end

		repeat (20) @(negedge clk);
		$display("Covered %0d control ticks (%0d with stop) across %0d gain settings.",
			ticks_taken, stop_ticks, settings_used);
		$display("Checked %0d results; %0d mismatches.", results_checked, err_count);
		if (err_count == 0 && drive_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
